// ===== rtl/oaht_pkg.sv =====
// shared types and constants of the open addressing hash table
package oaht_pkg;

   // request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // slot marks
   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_USED    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   // hash constants and the fill limit reset value
   localparam int          HASH_W       = 64;
   localparam logic [19:0] HASH_MULT    = 20'd1000003;
   localparam int          FIRST_SHIFT  = 7;
   localparam int          PERTURB_SHIFT = 5;
   localparam logic [6:0]  FILL_LIMIT_RESET = 7'd66;

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_MUL_LO,
      HS_MUL_HI
   } hash_state_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PR_HIT,
      PR_EMPTY,
      PR_EXHAUSTED
   } probe_result_type;

endpackage

// ===== rtl/oaht_hash.sv =====
// multiply-xor string hash; each character passes through a low-half then a high-half multiply state
module oaht_hash (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [oaht_pkg::HASH_W-1:0] key,
   input  logic [3:0]                  key_length,
   output logic                        done,
   output logic [oaht_pkg::HASH_W-1:0] hash
);
   import oaht_pkg::*;

   hash_state_type      state_ff, state_in;
   logic [HASH_W-1:0]   x_ff, x_in;
   logic [HASH_W-1:0]   key_ff, key_in;
   logic [3:0]          len_ff, len_in;
   logic [2:0]          n_ff, n_in;
   logic [51:0]         plo_ff, plo_in;
   logic                done_ff, done_in;
   logic [31:0]         phi;
   logic [HASH_W-1:0]   mixed;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      key_ff <= key_in;
      len_ff <= len_in;
      n_ff   <= n_in;
      plo_ff <= plo_in;
   end

   // high half product and the mixed word
   assign phi   = 32'(x_ff[63:32] * HASH_MULT);
   assign mixed = (64'(plo_ff) + {phi, 32'd0}) ^ 64'(key_ff[8*n_ff +: 8]);

   // next state
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      n_in     = n_ff;
      plo_in   = plo_ff;
      done_in  = 1'b0;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               key_in = key;
               len_in = key_length;
               n_in   = 3'd0;
               if (key_length == 4'd0) begin
                  x_in    = '0;
                  done_in = 1'b1;
               end else begin
                  x_in     = 64'(key[7:0]) << FIRST_SHIFT;
                  state_in = HS_MUL_LO;
               end
            end
         end
         HS_MUL_LO: begin
            plo_in   = x_ff[31:0] * HASH_MULT;
            state_in = HS_MUL_HI;
         end
         HS_MUL_HI: begin
            n_in = n_ff + 3'd1;
            if ({1'b0, n_ff} == len_ff - 4'd1) begin
               x_in     = mixed ^ 64'(len_ff);
               done_in  = 1'b1;
               state_in = HS_IDLE;
            end else begin
               x_in     = mixed;
               state_in = HS_MUL_LO;
            end
         end
         default: state_in = HS_IDLE;
      endcase
   end

   assign done = done_ff;
   assign hash = x_ff;

endmodule

// ===== rtl/oaht_mem.sv =====
// slot memory, one write and one registered read port
module oaht_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 102
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// Open addressing hash table with perturbed probing over TABLE_SLOTS slots in one slot
// memory. One request at a time: hashing steps through each key character, each probe
// reads memory, then compares, and a final step writes the slot if needed and sets the
// response; the hash multiplier and the single memory read port set the pace. A new
// request is taken while the previous response still waits. After reset a clearing pass
// marks every slot empty; no request is taken until it ends, while csr writes are taken
// at any time. TABLE_SLOTS must be a power of two.
module open_addressing_hash_table #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_CHARS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [8*KEY_CHARS-1:0] req_key_bytes,
   input  logic [3:0]             req_key_length,
   input  logic [31:0]            req_value_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_value_out,
   input  logic                   csr_write_en,
   input  logic [6:0]             csr_write_data
);
   import oaht_pkg::*;

   localparam int KEY_W       = 8 * KEY_CHARS;
   localparam int SW          = $clog2(TABLE_SLOTS);
   localparam int ENTRY_W     = 2 + 4 + KEY_W + 32;
   localparam int PROBE_LIMIT = TABLE_SLOTS + 16;
   localparam int PC_W        = $clog2(PROBE_LIMIT + 1);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   ctrl_state_type   state_ff, state_in;
   probe_result_type result_ff, result_in;
   logic [SW-1:0]    clr_ff, clr_in;
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [3:0]       len_ff, len_in;
   logic [31:0]      val_ff, val_in;
   logic [63:0]      i_ff, i_in;
   logic [63:0]      perturb_ff, perturb_in;
   logic [PC_W-1:0]  n_ff, n_in;
   logic [SW-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [6:0]       limit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;

   logic [3:0]       len_c;
   logic [KEY_W-1:0] key_c;
   logic             hash_start;
   logic             hash_done;
   logic [63:0]      hash_value;
   logic             wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic             rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [1:0]       e_mark;
   logic [3:0]       e_len;
   logic [KEY_W-1:0] e_key;
   logic [31:0]      e_value;
   logic             over_limit;

   // clamp the length and drop bytes past it
   assign len_c = (req_key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : req_key_length;
   always_comb begin
      for (int b = 0; b < KEY_CHARS; b++) begin
         key_c[8*b +: 8] = (b < int'(len_c)) ? req_key_bytes[8*b +: 8] : 8'd0;
      end
   end

   oaht_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hash_start),
      .key        (64'(key_c)),
      .key_length (len_c),
      .done       (hash_done),
      .hash       (hash_value)
   );

   oaht_mem #(
      .DEPTH (TABLE_SLOTS),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ((state_ff == S_CLEAR) ? clr_ff : addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (i_ff[SW-1:0]),
      .rd_data (rd_data)
   );

   // entry fields
   assign e_value = rd_data[31:0];
   assign e_key   = rd_data[KEY_W+31:32];
   assign e_len   = rd_data[KEY_W+35:KEY_W+32];
   assign e_mark  = rd_data[ENTRY_W-1:ENTRY_W-2];

   // fill limit: fill*100/slots > limit, in integer division
   assign over_limit = (32'(fill_ff) * 32'd100) >= ((32'(limit_ff) + 32'd1) * 32'(TABLE_SLOTS));

   // control and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         limit_ff     <= FILL_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
      end
      result_ff     <= result_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      val_ff        <= val_in;
      i_ff          <= i_in;
      perturb_ff    <= perturb_in;
      n_ff          <= n_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      result_in     = result_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      val_in        = val_ff;
      i_in          = i_ff;
      perturb_in    = perturb_ff;
      n_in          = n_ff;
      addr_in       = addr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      req_ready     = 1'b0;
      hash_start    = 1'b0;
      wr_en         = 1'b0;
      wr_data       = '0;
      rd_en         = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = {MARK_EMPTY, {(ENTRY_W-2){1'b0}}};
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == SW'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               hash_start = 1'b1;
               op_in      = req_type;
               key_in     = key_c;
               len_in     = len_c;
               val_in     = req_value_in;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               i_in       = hash_value;
               perturb_in = hash_value;
               n_in       = '0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            addr_in  = i_ff[SW-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (e_mark == MARK_EMPTY) begin
               result_in = PR_EMPTY;
               state_in  = S_FINISH;
            end else if (e_mark == MARK_USED && e_len == len_ff && e_key == key_ff) begin
               result_in = PR_HIT;
               state_in  = S_FINISH;
            end else begin
               // next slot on the probe path
               i_in       = (i_ff << 2) + i_ff + 64'd1 + perturb_ff;
               perturb_in = perturb_ff >> PERTURB_SHIFT;
               n_in       = n_ff + PC_W'(1);
               if (n_ff == PC_W'(PROBE_LIMIT - 1)) begin
                  result_in = PR_EXHAUSTED;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (result_ff == PR_HIT) begin
                        wr_en         = 1'b1;
                        wr_data       = {rd_data[ENTRY_W-1:32], val_ff};
                        rsp_status_in = STATUS_DONE;
                     end else if (result_ff == PR_EXHAUSTED || over_limit) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data       = {MARK_USED, len_ff, key_ff, val_ff};
                        fill_in       = fill_ff + CNT_W'(1);
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  OP_SEARCH: begin
                     if (result_ff == PR_HIT) begin
                        rsp_status_in = STATUS_DONE;
                        rsp_value_in  = e_value;
                     end
                  end
                  OP_DELETE: begin
                     if (result_ff == PR_HIT) begin
                        wr_en         = 1'b1;
                        wr_data       = {MARK_DELETED, rd_data[ENTRY_W-3:0]};
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  default: rsp_status_in = STATUS_NOT_FOUND;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule
